// ===== sv/mcl_pkg.sv =====
// Shared types, constants and helper functions of the mip chain layout block.
`default_nettype none

package mcl_pkg;

   // Port widths of the item channels and the register port.
   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 256;
   localparam int CSR_DATA_W = 17;

   // Register indexes.
   localparam logic CSR_LINE_STRIDE = 1'b0;
   localparam logic CSR_LAYER_ALIGN = 1'b1;

   // Reset values of the registers.
   localparam logic [6:0]  RESET_LINE_STRIDE = 7'd1;
   localparam logic [16:0] RESET_LAYER_ALIGN = 17'd4096;

   // Largest extent an image may have, and the 3D extent alignment minus one.
   localparam logic [14:0] MAX_EXTENT   = 15'd16384;
   localparam logic [14:0] ALIGN_3D_M1  = 15'd3;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL1,
      ST_MUL2,
      ST_STEP,
      ST_FIN_ALIGN,
      ST_FIN_MUL,
      ST_FIN_SUM
   } state_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic load_in;
      logic setup;
      logic mul1;
      logic mul2;
      logic step;
      logic fin_align;
      logic fin_mul;
      logic fin_sum;
   } cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic live;      // the current chain step contributes to the layer
      logic emit;      // the current step is a stored level
      logic out_free;  // the result register can take a new item
   } sts_type;

   // A zero extent counts as one, a large one saturates.
   function automatic logic [14:0] clamp_ext(input logic [14:0] v);
      logic [14:0] r;
      r = v;
      if (v == 15'd0) begin
         r = 15'd1;
      end else if (v > MAX_EXTENT) begin
         r = MAX_EXTENT;
      end
      return r;
   endfunction

   // Smallest power of two not below v; v is at least one.
   function automatic logic [14:0] pow2_up(input logic [14:0] v);
      logic [14:0] m;
      m = v - 15'd1;
      m = m | (m >> 1);
      m = m | (m >> 2);
      m = m | (m >> 4);
      m = m | (m >> 8);
      return m + 15'd1;
   endfunction

   // Next mip extent: half, never below one.
   function automatic logic [14:0] halve(input logic [14:0] v);
      logic [14:0] h;
      h = v >> 1;
      return (h == 15'd0) ? 15'd1 : h;
   endfunction

endpackage

`default_nettype wire

// ===== sv/mcl_ctrl.sv =====
// Sequencer of the mip chain layout block: walks setup, chain steps and finish.
`default_nettype none

module mcl_ctrl
   import mcl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            state_in = sts.live ? ST_MUL2 : ST_FIN_ALIGN;
         end
         ST_MUL2: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (!sts.emit || sts.out_free) begin
               state_in = ST_MUL1;
            end
         end
         ST_FIN_ALIGN: begin
            state_in = ST_FIN_MUL;
         end
         ST_FIN_MUL: begin
            state_in = ST_FIN_SUM;
         end
         ST_FIN_SUM: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands and the input handshake.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         ST_MUL1: begin
            cmd.mul1 = sts.live;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
         end
         ST_STEP: begin
            cmd.step = !sts.emit || sts.out_free;
         end
         ST_FIN_ALIGN: begin
            cmd.fin_align = 1'b1;
         end
         ST_FIN_MUL: begin
            cmd.fin_mul = 1'b1;
         end
         ST_FIN_SUM: begin
            cmd.fin_sum = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/mcl_dp.sv =====
// Datapath of the mip chain layout block: extents, products, sums and the result register.
`default_nettype none

module mcl_dp
   import mcl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   input  wire logic [6:0]            line_stride_align,
   input  wire logic [16:0]           layer_align,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   // Captured item fields.
   logic [14:0] w_raw_ff, w_raw_in, h_raw_ff, h_raw_in;
   logic [11:0] d_raw_ff, d_raw_in;
   logic [4:0]  bpe_ff, bpe_in;
   logic [3:0]  smp_ff, smp_in;
   logic [3:0]  lev_raw_ff, lev_raw_in;
   logic [11:0] layers_ff, layers_in;
   logic        is3d_ff, is3d_in, linear_ff, linear_in, rt_ff, rt_in;

   // Chain state.
   logic [14:0] w_ff, w_in, h_ff, h_in;
   logic [12:0] d_ff, d_in;
   logic [8:0]  sb_ff, sb_in;
   logic [3:0]  lev_ff, lev_in;
   logic [3:0]  k_ff, k_in;
   logic [60:0] acc_ff, acc_in;

   // Product stages.
   logic [19:0] pitch_ff, pitch_in;
   logic [23:0] sbw_ff, sbw_in;
   logic [27:0] hd_ff, hd_in;
   logic [14:0] hp_ff, hp_in;
   logic [51:0] size_ff, size_in;
   logic [43:0] plo_ff, plo_in;
   logic [28:0] phi_ff, phi_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  o_level_ff, o_level_in;
   logic [48:0] o_offset_ff, o_offset_in;
   logic [20:0] o_pitch_ff, o_pitch_in;
   logic [14:0] o_hp_ff, o_hp_in;
   logic [48:0] o_size_ff, o_size_in;
   logic [49:0] o_layer_ff, o_layer_in;
   logic [60:0] o_total_ff, o_total_in;
   logic        o_last_ff, o_last_in;

   // Combinational helpers.
   logic [14:0] wc, hc, dc, ls_m1, aw, ah;
   logic [12:0] ad;
   logic [16:0] la_m1;
   logic [40:0] phi_full;
   logic        is_last_level;

   // Status for the sequencer.
   always_comb begin
      sts.emit     = k_ff < lev_ff;
      sts.live     = (k_ff < lev_ff) ||
                     ((lev_ff != 4'd1) && !((w_ff == 15'd1) && (h_ff == 15'd1) &&
                                            (d_ff == 13'd1)));
      sts.out_free = !rsp_valid_ff || rsp_tready;
      is_last_level = k_ff == (lev_ff - 4'd1);
   end

   // Extents and alignments used by setup and the first product stage.
   always_comb begin
      wc    = clamp_ext(w_raw_ff);
      hc    = clamp_ext(h_raw_ff);
      dc    = clamp_ext({3'b000, d_raw_ff});
      ls_m1 = (line_stride_align == 7'd0) ? 15'd0 : {8'd0, line_stride_align - 7'd1};
      la_m1 = (layer_align == 17'd0) ? 17'd0 : layer_align - 17'd1;
      aw    = is3d_ff ? ((w_ff + ALIGN_3D_M1) & ~ALIGN_3D_M1) : w_ff;
      ah    = is3d_ff ? ((h_ff + ALIGN_3D_M1) & ~ALIGN_3D_M1) : h_ff;
      ad    = is3d_ff ? ((d_ff + ALIGN_3D_M1[12:0]) & ~ALIGN_3D_M1[12:0]) : d_ff;
      phi_full = 41'(acc_ff[60:32]) * 41'(layers_ff);
   end

   // Next values of the working registers.
   always_comb begin
      w_raw_in   = w_raw_ff;
      h_raw_in   = h_raw_ff;
      d_raw_in   = d_raw_ff;
      bpe_in     = bpe_ff;
      smp_in     = smp_ff;
      lev_raw_in = lev_raw_ff;
      layers_in  = layers_ff;
      is3d_in    = is3d_ff;
      linear_in  = linear_ff;
      rt_in      = rt_ff;
      w_in       = w_ff;
      h_in       = h_ff;
      d_in       = d_ff;
      sb_in      = sb_ff;
      lev_in     = lev_ff;
      k_in       = k_ff;
      acc_in     = acc_ff;
      pitch_in   = pitch_ff;
      sbw_in     = sbw_ff;
      hd_in      = hd_ff;
      hp_in      = hp_ff;
      size_in    = size_ff;
      plo_in     = plo_ff;
      phi_in     = phi_ff;

      // Take the item apart.
      if (cmd.load_in) begin
         w_raw_in   = req_tdata[14:0];
         h_raw_in   = req_tdata[29:15];
         d_raw_in   = req_tdata[41:30];
         bpe_in     = req_tdata[46:42];
         smp_in     = req_tdata[50:47];
         lev_raw_in = req_tdata[54:51];
         layers_in  = req_tdata[66:55];
         is3d_in    = req_tuser[0];
         linear_in  = req_tuser[1];
         rt_in      = req_tuser[2];
      end

      // Round the base extents and clear the running sums.
      if (cmd.setup) begin
         lev_in = (lev_raw_ff == 4'd0) ? 4'd1 : lev_raw_ff;
         sb_in  = 9'(smp_ff) * 9'(bpe_ff);
         k_in   = 4'd0;
         acc_in = 61'd0;
         w_in   = wc;
         h_in   = hc;
         d_in   = dc[12:0];
         if ((lev_raw_ff > 4'd1) || !linear_ff) begin
            w_in = pow2_up(wc);
            h_in = pow2_up(hc);
            d_in = 13'(pow2_up(dc));
         end else if (rt_ff) begin
            w_in = (wc + ls_m1) & ~ls_m1;
         end
      end

      // First product stage of one chain step.
      if (cmd.mul1) begin
         pitch_in = 20'(bpe_ff) * 20'(aw);
         sbw_in   = 24'(sb_ff) * 24'(aw);
         hd_in    = 28'(ah) * 28'(ad);
         hp_in    = ah;
      end

      // Second product stage: the level size.
      if (cmd.mul2) begin
         size_in = 52'(sbw_ff) * 52'(hd_ff);
      end

      // Sum the level into the layer and move down the chain.
      if (cmd.step) begin
         acc_in = acc_ff + 61'(size_ff);
         w_in   = halve(w_ff);
         h_in   = halve(h_ff);
         d_in   = 13'(halve({2'b00, d_ff}));
         k_in   = k_ff + 4'd1;
      end

      // Array images round the layer up.
      if (cmd.fin_align && (layers_ff > 12'd1)) begin
         acc_in = (acc_ff + 61'(la_m1)) & ~61'(la_m1);
      end

      // Layer times layer count, as two partial products.
      if (cmd.fin_mul) begin
         plo_in = 44'(acc_ff[31:0]) * 44'(layers_ff);
         phi_in = phi_full[28:0];
      end
   end

   // Next value of the result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      o_level_in   = o_level_ff;
      o_offset_in  = o_offset_ff;
      o_pitch_in   = o_pitch_ff;
      o_hp_in      = o_hp_ff;
      o_size_in    = o_size_ff;
      o_layer_in   = o_layer_ff;
      o_total_in   = o_total_ff;
      o_last_in    = o_last_ff;

      // A stored level loads the register; the final level stays hidden until the finish.
      if (cmd.step && sts.emit) begin
         o_level_in   = k_ff;
         o_offset_in  = acc_ff[48:0];
         o_pitch_in   = {1'b0, pitch_ff};
         o_hp_in      = hp_ff;
         o_size_in    = size_ff[48:0];
         o_layer_in   = 50'd0;
         o_total_in   = 61'd0;
         o_last_in    = 1'b0;
         rsp_valid_in = !is_last_level;
      end

      // Finish the final level with the layer and image sizes.
      if (cmd.fin_sum) begin
         o_layer_in   = acc_ff[49:0];
         o_total_in   = {phi_ff, 32'd0} + 61'(plo_ff);
         o_last_in    = 1'b1;
         rsp_valid_in = 1'b1;
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      w_raw_ff    <= w_raw_in;
      h_raw_ff    <= h_raw_in;
      d_raw_ff    <= d_raw_in;
      bpe_ff      <= bpe_in;
      smp_ff      <= smp_in;
      lev_raw_ff  <= lev_raw_in;
      layers_ff   <= layers_in;
      is3d_ff     <= is3d_in;
      linear_ff   <= linear_in;
      rt_ff       <= rt_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      d_ff        <= d_in;
      sb_ff       <= sb_in;
      lev_ff      <= lev_in;
      k_ff        <= k_in;
      acc_ff      <= acc_in;
      pitch_ff    <= pitch_in;
      sbw_ff      <= sbw_in;
      hd_ff       <= hd_in;
      hp_ff       <= hp_in;
      size_ff     <= size_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      o_level_ff  <= o_level_in;
      o_offset_ff <= o_offset_in;
      o_pitch_ff  <= o_pitch_in;
      o_hp_ff     <= o_hp_in;
      o_size_ff   <= o_size_in;
      o_layer_ff  <= o_layer_in;
      o_total_ff  <= o_total_in;
      o_last_ff   <= o_last_in;
   end

   // Result channel.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {7'd0, o_total_ff, o_layer_ff, o_size_ff, o_hp_ff, o_pitch_ff,
                        o_offset_ff, o_level_ff};

endmodule

`default_nettype wire

// ===== sv/mip_chain_layout.sv =====
// Top level of the mip chain layout block: register port, sequencer and datapath.
`default_nettype none

// One request item describes an image; the block answers with one result item per
// stored mip level, giving the level's offset within a layer, row pitch, height pitch
// and size, and the final result (tlast high) also carries the aligned layer size and
// the total image size. Items are worked one at a time: after acceptance the block
// takes a setup step, then one pass per step of the mip chain through its shared
// two-stage multiplier path, then checks for the end of the chain, aligns the layer and
// forms the total. With more than one level the chain runs for max(level count, log2
// of the largest rounded extent) steps, else for one step. A step that stores a level
// waits while the result channel stalls. The next item is taken once the final result
// is in the output register. The user must write registers through the csr port only
// while the block is idle; the block itself does not enforce this.
module mip_chain_layout
   import mcl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // From bit 0: width[15], height[15], depth[12], bytes_per_element[5], samples[4],
   // level_count[4], layer_count[12], zero fill.
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // From bit 0: is_3d, linear_layout, render_target.
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   // Result channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // From bit 0: level[4], level_offset[49], row_pitch[21], aligned_rows[15],
   // level_size[49], layer_bytes[50], image_bytes[61], zero fill.
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   // Register write port.
   input  wire logic                  csr_wen,
   input  wire logic                  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [6:0]  line_stride_ff, line_stride_in;
   logic [16:0] layer_align_ff, layer_align_in;
   cmd_type     cmd;
   sts_type     sts;

   // Register writes.
   always_comb begin
      line_stride_in = line_stride_ff;
      layer_align_in = layer_align_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_LINE_STRIDE: line_stride_in = csr_wdata[6:0];
            CSR_LAYER_ALIGN: layer_align_in = csr_wdata;
            default: begin
               line_stride_in = line_stride_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_stride_ff <= RESET_LINE_STRIDE;
         layer_align_ff <= RESET_LAYER_ALIGN;
      end else begin
         line_stride_ff <= line_stride_in;
         layer_align_ff <= layer_align_in;
      end
   end

   // Sequencer.
   mcl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath.
   mcl_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .line_stride_align (line_stride_ff),
      .layer_align       (layer_align_ff),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tlast         (rsp_tlast)
   );

endmodule

`default_nettype wire
